/* sv/keyed_record_table_unit_assert.svh */
// Assertion macros used by the table's top-level RTL file.
`ifndef KEYED_RECORD_TABLE_UNIT_ASSERT_SVH
`define KEYED_RECORD_TABLE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define KRT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition in one cycle implies a result in the next cycle.
`define KRT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define KRT_ASSERT(lbl, clk, rst, prop, msg)
`define KRT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

/* sv/kr_pkg.sv */
package kr_pkg;

  // Default table depth.
  localparam int CAPACITY = 16;

  // Field widths of the items.
  localparam int OP_W     = 3;
  localparam int KEY_W    = 16;
  localparam int QTY_W    = 16;
  localparam int PRICE_W  = 24;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;
  localparam int TOTAL_W  = 44;
  localparam int COUNT_W  = 5;
  localparam int PROD_W   = QTY_W + PRICE_W;
  localparam int IN_W     = 64;
  localparam int OUT_W    = 96;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 3'd1;
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
  localparam logic [OP_W-1:0] OP_TOTAL  = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  // One stored record.
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [QTY_W-1:0]   qty;
    logic [PRICE_W-1:0] price;
  } kr_rec_t;

  // Operation token that walks down the row of cells.
  typedef struct packed {
    logic               active;
    logic [OP_W-1:0]    op;
    logic               found;
    logic [KEY_W-1:0]   key;
    logic [QTY_W-1:0]   qty;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   fq;
    logic [PRICE_W-1:0] fp;
    logic [TOTAL_W-1:0] total;
    logic [PROD_W-1:0]  prod;
  } kr_tok_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIN
  } kr_state_t;

  // Running total plus one product, saturating at the largest total.
  function automatic logic [TOTAL_W-1:0] kr_sat_add(logic [TOTAL_W-1:0] a,
                                                    logic [PROD_W-1:0] b);
    logic [TOTAL_W:0] s;
    s = {1'b0, a} + (TOTAL_W+1)'(b);
    return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
  endfunction

endpackage

/* sv/kr_cell.sv */
module kr_cell #(
  parameter int IDX     = 0,
  parameter int CNT_W   = 5,
  parameter int SLOT_IW = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  kr_pkg::kr_tok_t      tok_in,
  input  logic [SLOT_IW-1:0]   slot_in,
  input  kr_pkg::kr_rec_t      next_rec,
  input  logic [CNT_W-1:0]     count,
  output kr_pkg::kr_tok_t      tok_out,
  output logic [SLOT_IW-1:0]   slot_out,
  output kr_pkg::kr_rec_t      rec
);

  localparam logic [CNT_W-1:0]   MY_IDX  = CNT_W'(IDX);
  localparam logic [SLOT_IW-1:0] MY_SLOT = SLOT_IW'(IDX);

  logic            live;
  logic            is_search;
  logic            match;
  logic            ins;
  logic            shift;
  kr_pkg::kr_tok_t t;
  logic [SLOT_IW-1:0] slot_next;

  // Decode what the passing token does to this cell.
  always_comb begin
    live      = MY_IDX < count;
    is_search = (tok_in.op == kr_pkg::OP_LOOKUP) || (tok_in.op == kr_pkg::OP_UPDATE) ||
                (tok_in.op == kr_pkg::OP_DELETE);
    match     = tok_in.active && live && is_search && !tok_in.found &&
                (rec.key == tok_in.key);
    ins       = tok_in.active && (tok_in.op == kr_pkg::OP_INSERT) && (MY_IDX == count);
    shift     = tok_in.active && (tok_in.op == kr_pkg::OP_DELETE) &&
                (match || tok_in.found);
  end

  // Token for the next cell: match results, then one step of the total.
  always_comb begin
    t         = tok_in;
    slot_next = slot_in;
    if (match || ins) begin
      t.found   = 1'b1;
      slot_next = MY_SLOT;
    end
    if (match && (tok_in.op == kr_pkg::OP_LOOKUP)) begin
      t.fq = rec.qty;
      t.fp = rec.price;
    end
    t.total = kr_pkg::kr_sat_add(tok_in.total, tok_in.prod);
    if (tok_in.active && (tok_in.op == kr_pkg::OP_TOTAL) && live) begin
      t.prod = kr_pkg::PROD_W'(rec.qty) * kr_pkg::PROD_W'(rec.price);
    end else begin
      t.prod = '0;
    end
  end

  // Token stage register; only the valid flag is reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else begin
      tok_out.active <= t.active;
    end
    tok_out.op    <= t.op;
    tok_out.found <= t.found;
    tok_out.key   <= t.key;
    tok_out.qty   <= t.qty;
    tok_out.price <= t.price;
    tok_out.fq    <= t.fq;
    tok_out.fp    <= t.fp;
    tok_out.total <= t.total;
    tok_out.prod  <= t.prod;
    slot_out      <= slot_next;
  end

  // Record held by this cell: append, quantity update or shift down on delete.
  always_ff @(posedge clk) begin
    if (ins) begin
      rec <= '{key: tok_in.key, qty: tok_in.qty, price: tok_in.price};
    end else if (shift) begin
      rec <= next_rec;
    end else if (match && (tok_in.op == kr_pkg::OP_UPDATE)) begin
      rec.qty <= tok_in.qty;
    end
  end

endmodule

/* sv/keyed_record_table_unit.sv */
// An accepted item passes the entry stage register, the token register of
// each record cell, the capture register and the output register to m_tvalid.
// The operation token walks the row one cell per cycle; the next item is taken
// only after the previous result has reached the output register.
// Reset: rst (synchronous, active high) empties the table and drops any item
// in flight; record contents are not cleared and need no clearing pass.
`include "keyed_record_table_unit_assert.svh"

module keyed_record_table_unit #(
  parameter int CAPACITY = kr_pkg::CAPACITY
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // op [2:0], key_id [18:3], quantity [34:19], unit_price [58:35], zeros above
  input  logic [kr_pkg::IN_W-1:0]   s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // status [1:0], slot [5:2], found_quantity [21:6], found_price [45:22],
  // total_value [89:46], entry_count [94:90], zero at [95]
  output logic [kr_pkg::OUT_W-1:0]  m_tdata
);

  localparam int SLOT_IW = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  kr_pkg::kr_state_t  state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  kr_pkg::kr_tok_t    tok  [CAPACITY+1];
  logic [SLOT_IW-1:0] slot [CAPACITY+1];
  kr_pkg::kr_rec_t    recs [CAPACITY];
  logic [CAPACITY:0]  tok_act;
  kr_pkg::kr_tok_t    head_tok;
  logic [SLOT_IW-1:0] head_slot;
  kr_pkg::kr_tok_t    tok_first;
  logic [SLOT_IW-1:0] slot_first;
  kr_pkg::kr_tok_t    fin;
  logic [SLOT_IW-1:0] fin_slot;

  logic accept;
  logic capture;
  logic load_out;

  logic [kr_pkg::STATUS_W-1:0]   res_status;
  logic [kr_pkg::TOTAL_W-1:0]    res_total;
  logic [SLOT_IW+kr_pkg::SLOT_W-1:0] slot_ext;
  logic [CNT_W+kr_pkg::COUNT_W-1:0]  cnt_ext;

  assign s_tready = (state == kr_pkg::S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Input token built from the accepted item.
  always_comb begin
    head_tok        = '0;
    head_tok.active = accept;
    head_tok.op     = s_tdata[2:0];
    head_tok.key    = s_tdata[18:3];
    head_tok.qty    = s_tdata[34:19];
    head_tok.price  = s_tdata[58:35];
    head_slot       = '0;
  end

  // Entry stage register in front of the first cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_first.active <= 1'b0;
    end else begin
      tok_first.active <= head_tok.active;
    end
    tok_first.op    <= head_tok.op;
    tok_first.found <= head_tok.found;
    tok_first.key   <= head_tok.key;
    tok_first.qty   <= head_tok.qty;
    tok_first.price <= head_tok.price;
    tok_first.fq    <= head_tok.fq;
    tok_first.fp    <= head_tok.fp;
    tok_first.total <= head_tok.total;
    tok_first.prod  <= head_tok.prod;
    slot_first      <= head_slot;
  end

  assign tok[0]  = tok_first;
  assign slot[0] = slot_first;

  // Row of record cells; each takes the token from its left neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    kr_pkg::kr_rec_t nrec;
    if (i == CAPACITY - 1) begin : g_last
      assign nrec = '0;
    end else begin : g_mid
      assign nrec = recs[i+1];
    end
    kr_cell #(
      .IDX     (i),
      .CNT_W   (CNT_W),
      .SLOT_IW (SLOT_IW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .tok_in   (tok[i]),
      .slot_in  (slot[i]),
      .next_rec (nrec),
      .count    (count),
      .tok_out  (tok[i+1]),
      .slot_out (slot[i+1]),
      .rec      (recs[i])
    );
  end

  for (genvar i = 0; i <= CAPACITY; i++) begin : g_act
    assign tok_act[i] = tok[i].active;
  end

  // Sequencer: wait for the token to leave the row, then hand off the result.
  always_comb begin
    state_next = state;
    capture    = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      kr_pkg::S_IDLE: begin
        if (accept) state_next = kr_pkg::S_RUN;
      end
      kr_pkg::S_RUN: begin
        if (tok[CAPACITY].active) begin
          capture    = 1'b1;
          state_next = kr_pkg::S_FIN;
        end
      end
      kr_pkg::S_FIN: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = kr_pkg::S_IDLE;
        end
      end
      default: state_next = kr_pkg::S_IDLE;
    endcase
  end

  // Result fields and the new record count.
  always_comb begin
    res_status = kr_pkg::ST_OK;
    count_next = count;
    unique case (fin.op)
      kr_pkg::OP_INSERT: begin
        if (count == CAP_CNT) res_status = kr_pkg::ST_FULL;
        else count_next = count + CNT_W'(1);
      end
      kr_pkg::OP_LOOKUP, kr_pkg::OP_UPDATE: begin
        if (!fin.found) res_status = kr_pkg::ST_MISSING;
      end
      kr_pkg::OP_DELETE: begin
        if (!fin.found) res_status = kr_pkg::ST_MISSING;
        else count_next = count - CNT_W'(1);
      end
      default: res_status = kr_pkg::ST_OK;
    endcase
    res_total = kr_pkg::kr_sat_add(fin.total, fin.prod);
    slot_ext  = (SLOT_IW+kr_pkg::SLOT_W)'(fin.found ? fin_slot : '0);
    cnt_ext   = (CNT_W+kr_pkg::COUNT_W)'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= kr_pkg::S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      fin      <= tok[CAPACITY];
      fin_slot <= slot[CAPACITY];
    end
    if (load_out) begin
      m_tdata <= {1'b0, cnt_ext[kr_pkg::COUNT_W-1:0], res_total, fin.fp, fin.fq,
                  slot_ext[kr_pkg::SLOT_W-1:0], res_status};
    end
  end

  // Checks on the sequencer and the token row.
  `KRT_ASSERT(a_count_range, clk, rst, count <= CAP_CNT, "record count above capacity")
  `KRT_ASSERT(a_one_token, clk, rst, $onehot0(tok_act), "more than one token in the row")
  `KRT_ASSERT_NEXT(a_accept_run, clk, rst, accept, (state == kr_pkg::S_RUN) && tok_act[0], "accepted item did not start a walk")
  `KRT_ASSERT(a_idle_empty, clk, rst, s_tready |-> (tok_act == '0), "ready while a token is in the row")

endmodule
